### src/mfa252_pkg.sv
package mfa252_pkg;

    // Operand and result widths
    localparam int LimbW  = 64;
    localparam int OpW    = 252;
    localparam int WordW  = 256;
    localparam int AccW   = 257;
    localparam int SumW   = 322;

    // Opcodes
    localparam logic [2:0] FUNC_MUL = 3'd0;
    localparam logic [2:0] FUNC_SQR = 3'd1;
    localparam logic [2:0] FUNC_ADD = 3'd2;
    localparam logic [2:0] FUNC_SUB = 3'd3;
    localparam logic [2:0] FUNC_NEG = 3'd4;

    // p = 2^251 + 17*2^192 + 1
    localparam logic [WordW-1:0] Prime =
        256'h0800000000000011_0000000000000000_0000000000000000_0000000000000001;

    // Request payload as it moves down the pipeline
    typedef struct packed {
        logic [2:0]       func;
        logic [OpW-1:0]   a;
        logic [OpW-1:0]   b;
        logic [WordW-1:0] lin;
    } item_t;

endpackage

### src/mfa252_linear.sv
module mfa252_linear (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  mfa252_pkg::item_t    in_item,
    output logic                 out_vld,
    output mfa252_pkg::item_t    out_item
);
    import mfa252_pkg::*;

    logic             s1_vld_reg;
    item_t            s1_item_reg;
    logic [WordW-1:0] s1_pre_reg;
    logic             s1_brw_reg;
    logic             s2_vld_reg;
    item_t            s2_item_reg;

    logic [WordW-1:0] s1_pre_next;
    logic             s1_brw_next;
    logic [WordW:0]   diff;
    logic [WordW:0]   sum_red;
    item_t            s2_item_next;

    // Stage 1: raw sum, difference or negation
    always_comb begin
        diff        = {5'd0, in_item.a} - {5'd0, in_item.b};
        s1_brw_next = diff[WordW];
        case (in_item.func)
            FUNC_ADD: s1_pre_next = {4'd0, in_item.a} + {4'd0, in_item.b};
            FUNC_SUB: s1_pre_next = diff[WordW-1:0];
            FUNC_NEG: begin
                if (in_item.a == '0) begin
                    s1_pre_next = '0;
                end else begin
                    s1_pre_next = Prime - {4'd0, in_item.a};
                end
            end
            default:  s1_pre_next = '0;
        endcase
    end

    // Stage 2: conditional correction by p
    always_comb begin
        sum_red      = {1'b0, s1_pre_reg} - {1'b0, Prime};
        s2_item_next = s1_item_reg;
        case (s1_item_reg.func)
            FUNC_ADD: s2_item_next.lin = sum_red[WordW] ? s1_pre_reg : sum_red[WordW-1:0];
            FUNC_SUB: s2_item_next.lin = s1_brw_reg ? s1_pre_reg + Prime : s1_pre_reg;
            FUNC_NEG: s2_item_next.lin = s1_pre_reg;
            default:  s2_item_next.lin = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
        if (en) begin
            s1_item_reg <= in_item;
            s1_pre_reg  <= s1_pre_next;
            s1_brw_reg  <= s1_brw_next;
            s2_item_reg <= s2_item_next;
        end
    end

    assign out_vld  = s2_vld_reg;
    assign out_item = s2_item_reg;

endmodule

### src/mfa252_round.sv
module mfa252_round (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_vld,
    input  mfa252_pkg::item_t               in_item,
    input  logic [mfa252_pkg::AccW-1:0]     in_t,
    output logic                            out_vld,
    output mfa252_pkg::item_t               out_item,
    output logic [mfa252_pkg::AccW-1:0]     out_t
);
    import mfa252_pkg::*;

    // Stage 1 registers: partial products of a_i * b_j
    logic             p1_vld_reg;
    item_t            p1_item_reg;
    logic [AccW-1:0]  p1_t_reg;
    logic [63:0]      pp_ll_reg [4];
    logic [63:0]      pp_lh_reg [4];
    logic [63:0]      pp_hl_reg [4];
    logic [63:0]      pp_hh_reg [4];
    // Stage 2 registers: two partial sums
    logic             p2_vld_reg;
    item_t            p2_item_reg;
    logic [SumW-1:0]  p2_u_reg;
    logic [SumW-1:0]  p2_v_reg;
    // Stage 3 register: t + a_i*B
    logic             p3_vld_reg;
    item_t            p3_item_reg;
    logic [SumW-1:0]  p3_w_reg;
    // Stage 4 registers: m*p top term and shifted accumulator
    logic             p4_vld_reg;
    item_t            p4_item_reg;
    logic [SumW-65:0] p4_hi_reg;
    logic [123:0]     p4_mp_reg;
    logic             p4_c_reg;
    // Stage 5 registers: new accumulator
    logic             p5_vld_reg;
    item_t            p5_item_reg;
    logic [AccW-1:0]  p5_t_reg;

    logic [WordW-1:0] b_pad;
    logic [63:0]      a_i;
    item_t            p1_item_next;
    logic [WordW-1:0] x1, x2, y1, y2;
    logic [SumW-1:0]  p2_u_next;
    logic [SumW-1:0]  p2_v_next;
    logic [63:0]      m;
    logic [123:0]     p4_mp_next;
    logic [AccW-1:0]  p5_t_next;

    // Operand limb for this round; the next round sees the following limb
    always_comb begin
        b_pad          = {4'd0, in_item.b};
        a_i            = in_item.a[63:0];
        p1_item_next   = in_item;
        p1_item_next.a = in_item.a >> LimbW;
    end

    // Line up partial products into four non-overlapping words
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            x1[64*j +: 64] = pp_ll_reg[j];
            x2[64*j +: 64] = pp_hh_reg[j];
            y1[64*j +: 64] = pp_lh_reg[j];
            y2[64*j +: 64] = pp_hl_reg[j];
        end
        p2_u_next = {65'd0, p1_t_reg} + {66'd0, x1} + {2'd0, x2, 64'd0};
        p2_v_next = {34'd0, y1, 32'd0} + {34'd0, y2, 32'd0};
    end

    // m = -t0 mod 2^64; m*p = m + m*(2^59 + 17)*2^192
    always_comb begin
        m          = ~p3_w_reg[63:0] + 64'd1;
        p4_mp_next = {1'b0, m, 59'd0} + {56'd0, m, 4'd0} + {60'd0, m};
        p5_t_next  = p4_hi_reg[AccW-1:0] + {{(AccW-1){1'b0}}, p4_c_reg}
                   + {5'd0, p4_mp_reg, 128'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= in_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
        end
        if (en) begin
            p1_item_reg <= p1_item_next;
            p1_t_reg    <= in_t;
            for (int j = 0; j < 4; j++) begin
                pp_ll_reg[j] <= a_i[31:0]  * b_pad[64*j +: 32];
                pp_lh_reg[j] <= a_i[31:0]  * b_pad[64*j+32 +: 32];
                pp_hl_reg[j] <= a_i[63:32] * b_pad[64*j +: 32];
                pp_hh_reg[j] <= a_i[63:32] * b_pad[64*j+32 +: 32];
            end
            p2_item_reg <= p1_item_reg;
            p2_u_reg    <= p2_u_next;
            p2_v_reg    <= p2_v_next;
            p3_item_reg <= p2_item_reg;
            p3_w_reg    <= p2_u_reg + p2_v_reg;
            p4_item_reg <= p3_item_reg;
            p4_hi_reg   <= p3_w_reg[SumW-1:64];
            p4_mp_reg   <= p4_mp_next;
            p4_c_reg    <= |p3_w_reg[63:0];
            p5_item_reg <= p4_item_reg;
            p5_t_reg    <= p5_t_next;
        end
    end

    assign out_vld  = p5_vld_reg;
    assign out_item = p5_item_reg;
    assign out_t    = p5_t_reg;

endmodule

### src/montgomery_field_alu_252_unit.sv
// Throughput: one request per cycle; the whole pipeline advances together,
// holding while a finished result waits on m_tready.
// Stages: 2 for add/sub/negate, 5 per Montgomery round (x4), 1 final subtract.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
module montgomery_field_alu_252_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_limb0, a_limb1, a_limb2, a_limb3, b_limb0, b_limb1, b_limb2, b_limb3
    input  logic [503:0] s_tdata,
    // func
    input  logic [7:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r_limb0, r_limb1, r_limb2, r_limb3, zero pad
    output logic [255:0] m_tdata
);
    import mfa252_pkg::*;

    logic              en;
    item_t             in_item;
    logic              lin_vld;
    item_t             lin_item;
    logic              rnd_vld  [5];
    item_t             rnd_item [5];
    logic [AccW-1:0]   rnd_t    [5];
    logic              out_vld_reg;
    logic [OpW-1:0]    r_reg;
    logic [OpW-1:0]    r_next;
    logic [WordW:0]    fin_d;
    logic [WordW-1:0]  mont_r;

    // Whole pipeline moves unless the output holds an untaken result
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Unpack request; square feeds a as both operands
    always_comb begin
        in_item.func = s_tuser[2:0];
        in_item.a    = s_tdata[251:0];
        in_item.b    = (s_tuser[2:0] == FUNC_SQR) ? s_tdata[251:0] : s_tdata[503:252];
        in_item.lin  = '0;
    end

    mfa252_linear u_linear (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_tvalid && s_tready),
        .in_item  (in_item),
        .out_vld  (lin_vld),
        .out_item (lin_item)
    );

    assign rnd_vld[0]  = lin_vld;
    assign rnd_item[0] = lin_item;
    assign rnd_t[0]    = '0;

    // Four CIOS rounds, one per operand limb
    for (genvar i = 0; i < 4; i++) begin : g_round
        mfa252_round u_round (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_vld   (rnd_vld[i]),
            .in_item  (rnd_item[i]),
            .in_t     (rnd_t[i]),
            .out_vld  (rnd_vld[i+1]),
            .out_item (rnd_item[i+1]),
            .out_t    (rnd_t[i+1])
        );
    end

    // Final conditional subtraction and result select
    always_comb begin
        fin_d  = {1'b0, rnd_t[4][WordW-1:0]} - {1'b0, Prime};
        mont_r = fin_d[WordW] ? rnd_t[4][WordW-1:0] : fin_d[WordW-1:0];
        case (rnd_item[4].func)
            FUNC_MUL: r_next = mont_r[OpW-1:0];
            FUNC_SQR: r_next = mont_r[OpW-1:0];
            FUNC_ADD: r_next = rnd_item[4].lin[OpW-1:0];
            FUNC_SUB: r_next = rnd_item[4].lin[OpW-1:0];
            FUNC_NEG: r_next = rnd_item[4].lin[OpW-1:0];
            default:  r_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= rnd_vld[4];
        end
        if (en) begin
            r_reg <= r_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, r_reg};

endmodule
